/* rtl/ssdc_pkg.sv */
// ssdc_pkg: shared constants, codes and controller/datapath structs for the
// sorted store delete-compact unit; no dependencies
package ssdc_pkg;

    localparam int unsigned PAGE_ENTRIES = 1024;
    localparam int unsigned PAGE_COUNT   = 16;
    localparam int unsigned DEPTH        = PAGE_ENTRIES * PAGE_COUNT;
    localparam int unsigned ADDR_W       = $clog2(DEPTH);
    localparam int unsigned CNT_W        = $clog2(DEPTH + 1);

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned IDX_W  = 14;

    localparam int unsigned S_TDATA_W = ((DATA_W + IDX_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W = ((STAT_W + DATA_W + 2 * CNT_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0]         DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic signed [DATA_W-1:0] FILLER    = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_ORDER = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;        // latch a new item, preset the result
        logic append;      // check and store the append value
        logic scan;        // one step of the delete scan
        logic scan_end;    // close the delete, update length
        logic read_issue;  // check index, start the store read
        logic read_take;   // capture the read data
        logic out_load;    // move the result into the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/ssdc_ram.sv */
// ssdc_ram: generic simple dual-port ram, one write and one read port,
// registered read data; no dependencies
module ssdc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ssdc_ctrl.sv */
// ssdc_ctrl: command sequencer for the sorted store unit
// depends on ssdc_pkg
module ssdc_ctrl
    import ssdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_cmd,
    output logic             o_in_ready,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_READ,
        S_RWAIT,
        S_FIN
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.load = 1'b1;
                    unique case (t_cmd'(i_in_cmd))
                        CMD_APPEND: n_state = S_APPEND;
                        CMD_DELETE: n_state = S_SCAN;
                        CMD_READ:   n_state = S_READ;
                        default:    n_state = S_FIN;
                    endcase
                end
            end
            S_APPEND: begin
                n_cmd.append = 1'b1;
                n_state      = S_FIN;
            end
            S_SCAN: begin
                n_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_cmd.scan_end = 1'b1;
                    n_state        = S_FIN;
                end
            end
            S_READ: begin
                n_cmd.read_issue = 1'b1;
                n_state          = S_RWAIT;
            end
            S_RWAIT: begin
                n_cmd.read_take = 1'b1;
                n_state         = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    n_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = n_cmd;

endmodule

/* rtl/ssdc_dp.sv */
// ssdc_dp: store, length, scan pointers, result and output registers
// depends on ssdc_pkg and ssdc_ram
module ssdc_dp
    import ssdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [DATA_W-1:0]    i_value,
    input  logic [IDX_W-1:0]     i_index,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [M_TDATA_W-1:0] o_out_data
);

    logic signed [DATA_W-1:0] r_value;
    logic [IDX_W-1:0]         r_index;
    logic [CNT_W-1:0]         r_count;
    logic signed [DATA_W-1:0] r_last;
    logic [CNT_W-1:0]         r_rd;
    logic [CNT_W-1:0]         r_wr;
    logic                     r_pv;
    t_status                  r_status;
    logic [DATA_W-1:0]        r_rv;
    logic [CNT_W-1:0]         r_removed;
    logic                     r_ovalid;
    logic [M_TDATA_W-1:0]     r_odata;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic append_ok;
    logic keep;
    logic rd_live;
    logic idx_ok;

    ssdc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        append_ok = (r_count < DEPTH_CNT) && (r_value != FILLER)
                    && ((r_count == '0) || (r_value >= r_last));
        keep      = r_pv && (ram_rdata != r_value);
        rd_live   = (r_rd < r_count);
        idx_ok    = (CNT_W'(r_index) < r_count);

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_value;
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (i_cmd.append && append_ok) begin
            ram_we    = 1'b1;
            ram_waddr = r_count[ADDR_W-1:0];
        end
        if (i_cmd.scan && keep) begin
            // write pointer trails the read pointer, so kept entries move down
            ram_we    = 1'b1;
            ram_waddr = r_wr[ADDR_W-1:0];
            ram_wdata = ram_rdata;
        end
        if (i_cmd.scan && rd_live) begin
            ram_re    = 1'b1;
            ram_raddr = r_rd[ADDR_W-1:0];
        end
        if (i_cmd.read_issue && idx_ok) begin
            ram_re    = 1'b1;
            ram_raddr = r_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd     <= '0;
            r_wr     <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_value   <= i_value;
                r_index   <= i_index;
                r_rd      <= '0;
                r_wr      <= '0;
                r_pv      <= 1'b0;
                r_status  <= ST_OK;
                r_rv      <= FILLER;
                r_removed <= '0;
            end
            if (i_cmd.append) begin
                if (r_count >= DEPTH_CNT) begin
                    r_status <= ST_FULL;
                end else if (!append_ok) begin
                    r_status <= ST_ORDER;
                end else begin
                    r_count <= r_count + 1'b1;
                    r_last  <= r_value;
                end
            end
            if (i_cmd.scan) begin
                r_pv <= rd_live;
                if (rd_live) begin
                    r_rd <= r_rd + 1'b1;
                end
                if (keep) begin
                    r_wr   <= r_wr + 1'b1;
                    r_last <= ram_rdata;
                end
            end
            if (i_cmd.scan_end) begin
                r_count   <= r_wr;
                r_removed <= r_count - r_wr;
            end
            if (i_cmd.read_issue) begin
                r_status <= idx_ok ? ST_OK : ST_RANGE;
            end
            if (i_cmd.read_take) begin
                r_rv <= (r_status == ST_OK) ? ram_rdata : FILLER;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
                r_odata  <= M_TDATA_W'({r_count, r_removed, r_rv, r_status});
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stat.scan_done = !rd_live && !r_pv;
    assign o_stat.out_free  = !r_ovalid || i_out_ready;
    assign o_out_valid      = r_ovalid;
    assign o_out_data       = r_odata;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("length beyond store depth");

    a_wr_trails_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr <= r_rd)
        else $error("compaction write pointer passed read pointer");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_end |=> r_count <= $past(r_count))
        else $error("delete grew the store");

    a_keep_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && keep) |-> (r_wr < r_count))
        else $error("compaction write beyond old length");

endmodule

/* rtl/sorted_store_delete_compact_unit.sv */
// sorted_store_delete_compact_unit: top level of the sorted store with append,
// delete-all-with-compaction and read; depends on ssdc_pkg, ssdc_ctrl, ssdc_dp
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: cmd; tdata: value, index
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: status, read_value,
//                                                     removed_count, length
//
// one command at a time; a delete scans every stored entry, reading one entry per
// cycle through the single read port of the store memory
// reset clears the length, scan pointers and output valid; the store itself needs no clearing pass
// a result waits in the output register while m_axis_tready is low; the
// sequencer holds the finished result and s_axis_tready stays low until then
module sorted_store_delete_compact_unit
    import ssdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave side
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // value[31:0], index[45:32], zero pad
    input  logic [CMD_W-1:0]     s_axis_tuser,  // cmd[1:0]
    // master side
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // status[1:0], read_value[33:2],
                                                // removed_count[48:34], length[63:49]
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;

    // input beat fields
    logic [DATA_W-1:0] in_value;
    logic [IDX_W-1:0]  in_index;

    assign in_value = s_axis_tdata[DATA_W-1:0];
    assign in_index = s_axis_tdata[DATA_W+IDX_W-1:DATA_W];

    // sequencer: picks the command path and paces the scan
    ssdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // store, pointers and the output register
    ssdc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_value     (in_value),
        .i_index     (in_index),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    assign s_axis_tready = in_ready;

endmodule

/* dv/testbench.sv */
// testbench for sorted_store_delete_compact_unit: directed and random
// command beats against an in-bench store tracker; needs ssdc_pkg and the rtl
`timescale 1ns / 100ps

module testbench
    import ssdc_pkg::*;
();

    // unused command code, must behave as a no-op
    localparam logic [CMD_W-1:0]         CMD_UNUSED  = 2'd3;
    localparam logic signed [DATA_W-1:0] TOP_VALUE   = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] LOW_VALUE   = 32'sh8000_0001;
    localparam int                       RANDOM_ITEMS = 19;   // per idling phase
    localparam int                       HOLD_OFF_CYCLES = 300;
    localparam int                       MAX_REPORTS = 10;

    // one result beat, laid out as on m_axis_tdata (msb first)
    typedef struct packed {
        logic [CNT_W-1:0]         length;
        logic [CNT_W-1:0]         removed;
        logic signed [DATA_W-1:0] rd_value;
        t_status                  status;
    } t_reply;

    // tracks the sorted store and holds the replies still owed by the block
    class store_tracker;
        logic signed [DATA_W-1:0] store_mem [DEPTH];
        int                       stored_len;
        t_reply                   pending_replies [$];
        int                       error_count;

        function new();
            stored_len  = 0;
            error_count = 0;
        endfunction

        // apply one accepted command and queue the reply it must produce
        function void note_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val,
                                   logic [IDX_W-1:0] idx);
            t_reply r;
            int     kept;
            r.status   = ST_OK;
            r.rd_value = FILLER;
            r.removed  = '0;
            case (cmd)
                CMD_APPEND: begin
                    if (stored_len >= DEPTH) begin
                        r.status = ST_FULL;
                    end else if (val == FILLER ||
                                 (stored_len > 0 &&
                                  val < store_mem[ADDR_W'(stored_len-1)])) begin
                        r.status = ST_ORDER;
                    end else begin
                        store_mem[ADDR_W'(stored_len)] = val;
                        stored_len++;
                    end
                end
                CMD_DELETE: begin
                    kept = 0;
                    for (int i = 0; i < stored_len; i++) begin
                        if (store_mem[ADDR_W'(i)] != val) begin
                            store_mem[ADDR_W'(kept)] = store_mem[ADDR_W'(i)];
                            kept++;
                        end
                    end
                    r.removed  = CNT_W'(stored_len - kept);
                    stored_len = kept;
                end
                CMD_READ: begin
                    if (int'(idx) < stored_len)
                        r.rd_value = store_mem[idx];
                    else
                        r.status = ST_RANGE;
                end
                default: ;
            endcase
            r.length = CNT_W'(stored_len);
            pending_replies.push_back(r);
        endfunction

        // compare one result beat with the oldest owed reply
        function void check_reply(logic [M_TDATA_W-1:0] beat);
            t_reply got;
            t_reply want;
            got = t_reply'(beat);
            if (pending_replies.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result beat: %h", beat);
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status || got.rd_value !== want.rd_value ||
                got.removed !== want.removed || got.length !== want.length) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display({"mismatch: status %0d/%0d value %0d/%0d removed %0d/%0d",
                              " length %0d/%0d (exp/got)"},
                             want.status, got.status, want.rd_value, got.rd_value,
                             want.removed, got.removed, want.length, got.length);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // value[31:0], index[45:32], zero pad
    logic [CMD_W-1:0]     s_axis_tuser = '0;   // cmd[1:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // status, read_value, removed_count, length

    store_tracker board = new();

    // idling knobs, percent of cycles
    int   send_idle_pct = 0;
    int   rx_stall_pct  = 0;
    logic rx_hold = 1'b0;
    event hold_off_trigger;

    sorted_store_delete_compact_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: check accepted beats, then pick the next tready
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_reply(m_axis_tdata);
            m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // long receiver hold-off so the block fills up and stalls its input
    always begin
        @(hold_off_trigger);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // offer one command beat and wait for it to be taken; valid stays high
    // for a back-to-back beat, so it is lowered only by the idle loop and at the end
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val,
                            input logic [IDX_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(S_TDATA_W-DATA_W-IDX_W){1'b0}}, idx, val};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        board.note_command(cmd, val, idx);
    endtask

    // mostly well-formed traffic: ascending appends, deletes of stored keys,
    // reads inside the length, with some noise mixed in
    task automatic send_random_cmd();
        int                       pick;
        int                       len;
        longint                   next_val;
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] val;
        logic [IDX_W-1:0]         idx;
        len  = board.stored_len;
        pick = $urandom_range(0, 99);
        val  = $urandom();
        idx  = IDX_W'($urandom_range(0, DEPTH - 1));
        if (pick < 50 && len < 48) begin
            cmd = CMD_APPEND;
            if (len > 0 && $urandom_range(0, 9) != 0) begin
                next_val = longint'(board.store_mem[ADDR_W'(len-1)]);
                if ($urandom_range(0, 3) == 0)
                    next_val += longint'($urandom_range(0, 1 << 24));
                else
                    next_val += longint'($urandom_range(0, 2));
                if (next_val > longint'(TOP_VALUE))
                    next_val = longint'(TOP_VALUE);
                val = next_val[DATA_W-1:0];
            end else if ($urandom_range(0, 9) == 0) begin
                val = FILLER;
            end
        end else if (pick < 75) begin
            cmd = CMD_DELETE;
            if (len > 0 && $urandom_range(0, 4) != 0)
                val = board.store_mem[ADDR_W'($urandom_range(0, len - 1))];
            else if ($urandom_range(0, 4) == 0)
                val = FILLER;
        end else if (pick < 95) begin
            cmd = CMD_READ;
            if (len > 0 && $urandom_range(0, 3) != 0)
                idx = IDX_W'($urandom_range(0, len - 1));
        end else begin
            cmd = CMD_UNUSED;
        end
        send_cmd(cmd, val, idx);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store corner cases
        send_cmd(CMD_READ, 32'sd0, '0);              // read on empty store
        send_cmd(CMD_DELETE, 32'sd5, '0);            // delete on empty store
        send_cmd(CMD_APPEND, FILLER, '1);            // filler is never stored
        // appends, including equal values and one out of order
        send_cmd(CMD_APPEND, LOW_VALUE, '0);
        send_cmd(CMD_APPEND, LOW_VALUE, '0);
        send_cmd(CMD_APPEND, -32'sd5, '0);
        send_cmd(CMD_APPEND, -32'sd6, '0);           // below last entry
        send_cmd(CMD_APPEND, 32'sd0, '0);
        send_cmd(CMD_APPEND, 32'sd0, '0);
        send_cmd(CMD_APPEND, 32'sd0, '0);
        send_cmd(CMD_APPEND, TOP_VALUE, '0);
        send_cmd(CMD_APPEND, TOP_VALUE, '0);
        send_cmd(CMD_UNUSED, $urandom(), IDX_W'($urandom_range(0, DEPTH - 1)));
        // reads inside and past the length
        send_cmd(CMD_READ, $urandom(), 14'd0);
        send_cmd(CMD_READ, $urandom(), 14'd2);
        send_cmd(CMD_READ, $urandom(), 14'd7);
        send_cmd(CMD_READ, $urandom(), 14'd8);
        send_cmd(CMD_READ, $urandom(), '1);
        // deletes: filler key, absent key, runs of equal entries
        send_cmd(CMD_DELETE, FILLER, '0);
        send_cmd(CMD_DELETE, 32'sd3, '0);
        send_cmd(CMD_DELETE, 32'sd0, '0);
        send_cmd(CMD_DELETE, LOW_VALUE, '0);
        send_cmd(CMD_READ, $urandom(), 14'd0);
        send_cmd(CMD_DELETE, -32'sd5, '0);
        send_cmd(CMD_DELETE, TOP_VALUE, '0);

        // random traffic over the idling phases
        -> hold_off_trigger;                         // sender keeps offering meanwhile
        repeat (RANDOM_ITEMS) send_random_cmd();
        send_idle_pct = 56;
        repeat (RANDOM_ITEMS) send_random_cmd();
        send_idle_pct = 0;
        rx_stall_pct  = 56;
        repeat (RANDOM_ITEMS) send_random_cmd();
        send_idle_pct = 9;
        rx_stall_pct  = 9;
        repeat (RANDOM_ITEMS) send_random_cmd();
        s_axis_tvalid <= 1'b0;

        // drain, then watch for stray beats
        while (board.pending_replies.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (board.error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // timeout well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
